>>> design/rvild_pkg.sv
// ----------------------------------------------------------------------------
// rvild_pkg
// Shared types and constants for the RV32I immediate and load execute block.
// ----------------------------------------------------------------------------
package rvild_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam logic [5:0] REG_LIMIT = 6'(REG_COUNT);

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_OPIMMW = 7'h1B;
    localparam logic [6:0] OPC_LUI    = 7'h37;

    localparam logic [2:0] F3_ADD  = 3'b000;
    localparam logic [2:0] F3_SLL  = 3'b001;
    localparam logic [2:0] F3_SLT  = 3'b010;
    localparam logic [2:0] F3_SLTU = 3'b011;
    localparam logic [2:0] F3_XOR  = 3'b100;
    localparam logic [2:0] F3_SR   = 3'b101;
    localparam logic [2:0] F3_OR   = 3'b110;
    localparam logic [2:0] F3_AND  = 3'b111;

    localparam logic [2:0] F3_LB  = 3'b000;
    localparam logic [2:0] F3_LH  = 3'b001;
    localparam logic [2:0] F3_LBU = 3'b100;
    localparam logic [2:0] F3_LHU = 3'b101;

    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_DBL  = 2'd3;

    localparam logic ACT_EXEC = 1'b0;
    localparam logic ACT_DATA = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ILLEGAL   = 2'd1,
        ST_NO_LOAD   = 2'd2,
        ST_LOAD_BUSY = 2'd3
    } t_status;

    typedef struct packed {
        logic        action;
        logic [31:0] instruction;
        logic [31:0] load_data;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] pc_after;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_read;
        logic [31:0] mem_address;
        logic [1:0]  mem_size;
    } t_out_item;

    typedef struct packed {
        logic [31:0] pc;
        logic        pending;
        logic [4:0]  dest;
        logic [2:0]  kind;
    } t_state;

    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] addr;
        logic [31:0]          data;
    } t_rf_wr;

endpackage

>>> design/rvild_regfile.sv
// ----------------------------------------------------------------------------
// rvild_regfile
// Integer register file in flops, one write and one read port; x0 reads zero.
// ----------------------------------------------------------------------------
module rvild_regfile
    import rvild_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rf_wr      i_wr,
    input  logic [4:0]  i_raddr,
    output logic [31:0] o_rdata
);

    logic [31:0] r_regs [REG_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else if (i_wr.we) begin
            r_regs[i_wr.addr] <= i_wr.data;
        end
    end

    always_comb begin
        if (i_raddr == 5'd0 || {1'b0, i_raddr} >= REG_LIMIT) begin
            o_rdata = '0;
        end else begin
            o_rdata = r_regs[i_raddr[REG_IDX_W-1:0]];
        end
    end

endmodule

>>> design/rvild_exec.sv
// ----------------------------------------------------------------------------
// rvild_exec
// Decode and execute of one item: result, next state and register write.
// ----------------------------------------------------------------------------
module rvild_exec
    import rvild_pkg::*;
(
    input  t_in_item    i_item,
    input  t_state      i_state,
    input  logic [31:0] i_rs1_data,
    output t_out_item   o_result,
    output t_state      o_state,
    output t_rf_wr      o_wr
);

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [31:0] imm;
    logic [31:0] uimm;
    logic        rd_ok;
    logic        rs_ok;
    logic [31:0] alu;
    logic [31:0] ld_val;
    logic [31:0] pc_inc;
    logic        wb;
    logic [4:0]  wb_idx;
    logic [31:0] wb_val;

    assign opc    = i_item.instruction[6:0];
    assign rd     = i_item.instruction[11:7];
    assign f3     = i_item.instruction[14:12];
    assign rs1    = i_item.instruction[19:15];
    assign imm    = {{20{i_item.instruction[31]}}, i_item.instruction[31:20]};
    assign uimm   = {i_item.instruction[31:12], 12'd0};
    assign rd_ok  = {1'b0, rd} < REG_LIMIT;
    assign rs_ok  = {1'b0, rs1} < REG_LIMIT;
    assign pc_inc = i_state.pc + 32'd4;

    always_comb begin
        unique case (f3)
            F3_ADD:  alu = i_rs1_data + imm;
            F3_SLT:  alu = {31'd0, $signed(i_rs1_data) < $signed(imm)};
            F3_SLTU: alu = {31'd0, i_rs1_data < imm};
            F3_XOR:  alu = i_rs1_data ^ imm;
            F3_OR:   alu = i_rs1_data | imm;
            default: alu = i_rs1_data & imm;
        endcase
    end

    always_comb begin
        unique case (i_state.kind)
            F3_LB:   ld_val = {{24{i_item.load_data[7]}}, i_item.load_data[7:0]};
            F3_LBU:  ld_val = {24'd0, i_item.load_data[7:0]};
            F3_LH:   ld_val = {{16{i_item.load_data[15]}}, i_item.load_data[15:0]};
            F3_LHU:  ld_val = {16'd0, i_item.load_data[15:0]};
            default: ld_val = i_item.load_data;
        endcase
    end

    always_comb begin
        o_result        = '0;
        o_result.status = ST_OK;
        o_state         = i_state;
        wb              = 1'b0;
        wb_idx          = rd;
        wb_val          = '0;

        if (i_item.action == ACT_DATA) begin
            if (!i_state.pending) begin
                o_result.status = ST_NO_LOAD;
            end else begin
                wb              = 1'b1;
                wb_idx          = i_state.dest;
                wb_val          = ld_val;
                o_state.pending = 1'b0;
            end
        end else if (i_state.pending) begin
            o_result.status = ST_LOAD_BUSY;
        end else if ((opc == OPC_OPIMM || (opc == OPC_OPIMMW && f3 == F3_ADD))
                     && f3 != F3_SLL && f3 != F3_SR && rd_ok && rs_ok) begin
            wb         = 1'b1;
            wb_val     = alu;
            o_state.pc = pc_inc;
        end else if (opc == OPC_LUI && rd_ok) begin
            wb         = 1'b1;
            wb_val     = uimm;
            o_state.pc = pc_inc;
        end else if (opc == OPC_AUIPC && rd_ok) begin
            wb         = 1'b1;
            wb_val     = i_state.pc + uimm;
            o_state.pc = pc_inc;
        end else if (opc == OPC_LOAD && f3 != F3_AND && rd_ok && rs_ok) begin
            o_result.mem_read    = 1'b1;
            o_result.mem_address = i_rs1_data + imm;
            o_result.mem_size    = (f3[1:0] == SIZE_DBL) ? SIZE_WORD : f3[1:0];
            o_state.pending      = 1'b1;
            o_state.dest         = rd;
            o_state.kind         = f3;
            o_state.pc           = pc_inc;
        end else begin
            o_result.status = ST_ILLEGAL;
        end

        // x0 destination: completes but nothing is written
        if (wb && wb_idx != 5'd0) begin
            o_result.reg_write = 1'b1;
            o_result.reg_index = wb_idx;
            o_result.reg_value = wb_val;
        end
        o_result.pc_after = o_state.pc;

        o_wr.we   = o_result.reg_write;
        o_wr.addr = wb_idx[REG_IDX_W-1:0];
        o_wr.data = wb_val;
    end

endmodule

>>> design/rv32i_imm_load_execute.sv
// ----------------------------------------------------------------------------
// rv32i_imm_load_execute
// RV32I execute for OP-IMM, lui, auipc and loads, with load data write-back.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data): an instruction or a
// load data item, one transfer per cycle at most. Output channel
// (o_out_valid / i_out_stall / o_out_data): exactly one result per item,
// in order. Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data):
// writes start_pc, which also loads the program counter; always ready.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single pass through the decode/execute logic between the input
// register and the result register; register file, pc and load state
// update at the edge that registers the result, so the following item
// sees them.
// Reset clears the register file, pc (to zero), the pending load and both
// pipeline valid flags. When the receiver stalls, the result register holds;
// the input register still fills, and o_in_stall rises once both are full.
// ----------------------------------------------------------------------------
module rv32i_imm_load_execute
    import rvild_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    t_in_item    r_in;
    logic        r_in_valid;
    t_out_item   r_out;
    logic        r_out_valid;
    t_state      r_state;
    t_state      n_state;
    t_out_item   n_out;
    t_rf_wr      rf_wr;
    t_rf_wr      rf_wr_gated;
    logic [31:0] rs1_data;
    logic        advance;
    logic        in_xfer;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        rf_wr_gated    = rf_wr;
        rf_wr_gated.we = rf_wr.we && advance;
    end

    rvild_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rf_wr_gated),
        .i_raddr (r_in.instruction[19:15]),
        .o_rdata (rs1_data)
    );

    rvild_exec u_exec (
        .i_item     (r_in),
        .i_state    (r_state),
        .i_rs1_data (rs1_data),
        .o_result   (n_out),
        .o_state    (n_state),
        .o_wr       (rf_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_state.pc <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

>>> tb/rv32i_imm_load_execute_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_imm_load_execute_checker
// Watches the input, output and start_pc channels of the execute block. Every
// accepted item is run through a local model of the register file, pc and
// pending load. The predicted result is queued and compared field by field
// with the next result the block delivers.
// ----------------------------------------------------------------------------
module rv32i_imm_load_execute_checker
    import rvild_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_open_count,
    output int          o_checked_count
);

    logic [31:0] gpr [REG_COUNT];
    logic [31:0] pc_q;
    logic        ld_pending;
    logic [4:0]  ld_dest;
    logic [2:0]  ld_kind;

    t_out_item   retire_q [$];
    int          fail_n    = 0;
    int          checked_n = 0;

    function automatic t_out_item write_back(t_out_item r, logic [4:0] rd, logic [31:0] v);
        if (rd != 5'd0 && {1'b0, rd} < REG_LIMIT) begin
            gpr[rd]     = v;
            r.reg_write = 1'b1;
            r.reg_index = rd;
            r.reg_value = v;
        end
        return r;
    endfunction

    function automatic t_out_item execute_item(t_in_item it);
        t_out_item   r;
        logic [6:0]  opc;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [2:0]  f3;
        logic [31:0] imm;
        logic [31:0] uimm;
        logic [31:0] a;
        logic [31:0] d;
        logic [31:0] v;
        logic        rd_ok;
        logic        rs_ok;
        r        = '0;
        r.status = ST_OK;
        opc      = it.instruction[6:0];
        rd       = it.instruction[11:7];
        f3       = it.instruction[14:12];
        rs1      = it.instruction[19:15];
        imm      = {{20{it.instruction[31]}}, it.instruction[31:20]};
        uimm     = {it.instruction[31:12], 12'h000};
        rd_ok    = {1'b0, rd} < REG_LIMIT;
        rs_ok    = {1'b0, rs1} < REG_LIMIT;
        a        = (rs1 == 5'd0 || !rs_ok) ? 32'h0 : gpr[rs1];
        d        = it.load_data;
        if (it.action == ACT_DATA) begin
            if (!ld_pending) begin
                r.status = ST_NO_LOAD;
            end else begin
                case (ld_kind)
                    F3_LB:   v = {{24{d[7]}}, d[7:0]};
                    F3_LBU:  v = {24'h0, d[7:0]};
                    F3_LH:   v = {{16{d[15]}}, d[15:0]};
                    F3_LHU:  v = {16'h0, d[15:0]};
                    default: v = d;
                endcase
                r          = write_back(r, ld_dest, v);
                ld_pending = 1'b0;
            end
        end else if (ld_pending) begin
            r.status = ST_LOAD_BUSY;
        end else if ((opc == OPC_OPIMM || (opc == OPC_OPIMMW && f3 == F3_ADD)) &&
                     f3 != F3_SLL && f3 != F3_SR && rd_ok && rs_ok) begin
            case (f3)
                F3_ADD:  v = a + imm;
                F3_SLT:  v = {31'h0, $signed(a) < $signed(imm)};
                F3_SLTU: v = {31'h0, a < imm};
                F3_XOR:  v = a ^ imm;
                F3_OR:   v = a | imm;
                default: v = a & imm;
            endcase
            r    = write_back(r, rd, v);
            pc_q = pc_q + 32'd4;
        end else if (opc == OPC_LUI && rd_ok) begin
            r    = write_back(r, rd, uimm);
            pc_q = pc_q + 32'd4;
        end else if (opc == OPC_AUIPC && rd_ok) begin
            r    = write_back(r, rd, pc_q + uimm);
            pc_q = pc_q + 32'd4;
        end else if (opc == OPC_LOAD && f3 != F3_AND && rd_ok && rs_ok) begin
            // funct3 7 has no load
            r.mem_read    = 1'b1;
            r.mem_address = a + imm;
            r.mem_size    = (f3[1:0] == SIZE_DBL) ? SIZE_WORD : f3[1:0];
            ld_pending    = 1'b1;
            ld_dest       = rd;
            ld_kind       = f3;
            pc_q          = pc_q + 32'd4;
        end else begin
            r.status = ST_ILLEGAL;
        end
        r.pc_after = pc_q;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_n++;
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) gpr[i] = 32'h0;
            pc_q       = 32'h0;
            ld_pending = 1'b0;
            ld_dest    = 5'd0;
            ld_kind    = 3'd0;
            retire_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                pc_q = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (retire_q.size() == 0) begin
                    $error("result transfer with nothing outstanding");
                    fail_n++;
                end else begin
                    want = retire_q.pop_front();
                    check_field("status", 32'(want.status), 32'(i_out_data.status));
                    check_field("pc_after", want.pc_after, i_out_data.pc_after);
                    check_field("reg_write", 32'(want.reg_write), 32'(i_out_data.reg_write));
                    check_field("reg_index", 32'(want.reg_index), 32'(i_out_data.reg_index));
                    check_field("reg_value", want.reg_value, i_out_data.reg_value);
                    check_field("mem_read", 32'(want.mem_read), 32'(i_out_data.mem_read));
                    check_field("mem_address", want.mem_address, i_out_data.mem_address);
                    check_field("mem_size", 32'(want.mem_size), 32'(i_out_data.mem_size));
                    checked_n++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                retire_q.push_back(execute_item(i_in_data));
            end
        end
        o_open_count    <= retire_q.size();
        o_fail_count    <= fail_n;
        o_checked_count <= checked_n;
    end

endmodule

>>> tb/tb_rv32i_imm_load_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rv32i_imm_load_execute
// Drives the execute block with directed OP-IMM, lui, auipc and load cases,
// then constrained-by-hand random programs of mostly legal instructions and
// load/data pairs mixed with illegal words and stray data. start_pc is
// rewritten between phases. Input bursts and output stalls are random.
// ----------------------------------------------------------------------------
module tb_rv32i_imm_load_execute;
    import rvild_pkg::*;

    localparam logic [2:0] F3_LD  = 3'b011;
    localparam logic [2:0] F3_LWU = 3'b110;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    int          fail_count;
    int          open_count;
    int          checked_count;

    bit          long_hold;
    int          burst_left;
    int          items_sent;
    int          loads_sent;
    int          pc_settings;

    logic [2:0]  alu_f3 [6] = '{F3_ADD, F3_SLT, F3_SLTU, F3_XOR, F3_OR, F3_AND};

    rv32i_imm_load_execute dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    rv32i_imm_load_execute_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_in_data       (i_in_data),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_data      (o_out_data),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_open_count    (open_count),
        .o_checked_count (checked_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("[rv32i_imm_load_execute] ERROR");
        $finish;
    end

    // result side: stall pattern switches among random modes; long_hold adds a held stall
    initial begin : rx_pattern
        int mode;
        int span;
        bit held;
        i_out_stall = 1'b0;
        mode        = 0;
        span        = 0;
        held        = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold && !held) begin
                i_out_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
                held = 1'b1;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 120);
            end
            span--;
            case (mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    function automatic logic [31:0] enc_i(logic [6:0] opc, logic [4:0] rd, logic [2:0] f3,
                                          logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_u(logic [6:0] opc, logic [4:0] rd, logic [19:0] imm);
        return {imm, rd, opc};
    endfunction

    function automatic logic [11:0] rand_imm();
        case ($urandom_range(0, 7))
            0:       return 12'h000;
            1:       return 12'h7FF;
            2:       return 12'h800;
            3:       return 12'hFFF;
            default: return 12'($urandom());
        endcase
    endfunction

    function automatic logic [4:0] rand_reg();
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [31:0] rand_alu_word();
        case ($urandom_range(0, 9))
            0:       return enc_u(OPC_LUI, rand_reg(), 20'($urandom()));
            1:       return enc_u(OPC_AUIPC, rand_reg(), 20'($urandom()));
            2:       return enc_i(OPC_OPIMMW, rand_reg(), F3_ADD, rand_reg(), rand_imm());
            default: return enc_i(OPC_OPIMM, rand_reg(), alu_f3[$urandom_range(0, 5)],
                                  rand_reg(), rand_imm());
        endcase
    endfunction

    function automatic logic [31:0] rand_bad_word();
        case ($urandom_range(0, 4))
            0:       return enc_i(OPC_OPIMM, rand_reg(), F3_SLL, rand_reg(), rand_imm());
            1:       return enc_i(OPC_OPIMM, rand_reg(), F3_SR, rand_reg(), rand_imm());
            2:       return enc_i(OPC_OPIMMW, rand_reg(), 3'($urandom_range(1, 7)),
                                  rand_reg(), rand_imm());
            3:       return enc_i(OPC_LOAD, rand_reg(), F3_AND, rand_reg(), rand_imm());
            default: return $urandom();
        endcase
    endfunction

    // one transfer on the input channel, with random gaps between bursts
    task automatic send(t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_exec(logic [31:0] w);
        t_in_item it;
        it.action      = ACT_EXEC;
        it.instruction = w;
        it.load_data   = $urandom();
        if (w[6:0] == OPC_LOAD) loads_sent++;
        send(it);
    endtask

    task automatic send_data(logic [31:0] d);
        t_in_item it;
        it.action      = ACT_DATA;
        it.instruction = $urandom();
        it.load_data   = d;
        send(it);
    endtask

    task automatic write_start_pc(logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        pc_settings++;
    endtask

    task automatic wait_retired();
        i_in_valid <= 1'b0;
        while (open_count != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic directed_cases();
        send_data(32'hFFFF_FFFF);
        send_exec(enc_u(OPC_LUI, 5'd1, 20'hFFFFF));
        send_exec(enc_i(OPC_OPIMM, 5'd2, F3_ADD, 5'd0, 12'hFFF));
        send_exec(enc_i(OPC_OPIMM, 5'd3, F3_ADD, 5'd0, 12'h7FF));
        send_exec(enc_i(OPC_OPIMM, 5'd0, F3_ADD, 5'd1, 12'h005));
        send_exec(enc_i(OPC_OPIMM, 5'd4, F3_SLT, 5'd2, 12'h000));
        send_exec(enc_i(OPC_OPIMM, 5'd5, F3_SLTU, 5'd3, 12'hFFF));
        send_exec(enc_i(OPC_OPIMM, 5'd6, F3_XOR, 5'd2, 12'h555));
        send_exec(enc_i(OPC_OPIMM, 5'd7, F3_OR, 5'd1, 12'h7FF));
        send_exec(enc_i(OPC_OPIMM, 5'd31, F3_AND, 5'd2, 12'h800));
        send_exec(enc_i(OPC_OPIMMW, 5'd9, F3_ADD, 5'd3, 12'h001));
        send_exec(enc_i(OPC_OPIMMW, 5'd9, F3_SLT, 5'd3, 12'h001));
        send_exec(enc_i(OPC_OPIMM, 5'd9, F3_SLL, 5'd3, 12'h01F));
        send_exec(enc_i(OPC_OPIMM, 5'd9, F3_SR, 5'd3, 12'h41F));
        send_exec(enc_u(OPC_AUIPC, 5'd10, 20'h80000));
        send_exec(enc_i(OPC_LOAD, 5'd11, F3_LB, 5'd1, 12'hFFF));
        send_data(32'h0000_0080);
        send_exec(enc_i(OPC_LOAD, 5'd12, F3_LH, 5'd3, 12'h800));
        send_exec(enc_u(OPC_LUI, 5'd13, 20'h12345));
        send_data(32'h1234_8001);
        send_exec(enc_i(OPC_LOAD, 5'd13, F3_LBU, 5'd2, 12'h000));
        send_data(32'hFFFF_FFFF);
        send_exec(enc_i(OPC_LOAD, 5'd14, F3_LHU, 5'd31, 12'h7FF));
        send_data(32'hFFFF_8001);
        send_exec(enc_i(OPC_LOAD, 5'd0, F3_LD, 5'd6, 12'h010));
        send_data(32'h89AB_CDEF);
        send_exec(enc_i(OPC_LOAD, 5'd15, F3_LWU, 5'd7, 12'h004));
        send_data(32'h0000_0000);
        send_exec(enc_i(OPC_LOAD, 5'd16, F3_AND, 5'd0, 12'h000));
        send_exec(32'h0000_0000);
        send_exec(32'hFFFF_FFFF);
    endtask

    task automatic random_traffic(int n);
        int target;
        target = items_sent + n;
        while (items_sent < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_exec(rand_alu_word());
                6, 7: begin
                    send_exec(enc_i(OPC_LOAD, rand_reg(), 3'($urandom_range(0, 6)),
                                    rand_reg(), rand_imm()));
                    if ($urandom_range(0, 5) == 0) send_exec(rand_alu_word());
                    send_data($urandom());
                end
                8: send_exec(rand_bad_word());
                default: begin
                    if ($urandom_range(0, 1) == 0) send_data($urandom());
                    else send_exec($urandom());
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 32'h0;
        long_hold   = 1'b0;
        burst_left  = 0;
        items_sent  = 0;
        loads_sent  = 0;
        pc_settings = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_start_pc(32'h0000_0000);
        directed_cases();
        wait_retired();

        write_start_pc(32'hFFFF_FFFF);
        random_traffic(100);
        wait_retired();

        // result side held off while items keep coming
        write_start_pc(32'hFFFF_FFFC);
        random_traffic(30);
        long_hold = 1'b1;
        random_traffic(70);
        wait_retired();

        write_start_pc($urandom());
        random_traffic(75);
        wait_retired();
        random_traffic(75);
        wait_retired();

        write_start_pc(32'h8000_0000);
        random_traffic(150);
        wait_retired();

        $display("Sent %0d items (%0d loads) across %0d start_pc settings; %0d results checked.",
                 items_sent, loads_sent, pc_settings, checked_count);
        if (fail_count == 0 && open_count == 0) begin
            $display("[rv32i_imm_load_execute] OK");
        end else begin
            $display("[rv32i_imm_load_execute] ERROR");
        end
        $finish;
    end

endmodule
